@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`ifndef NO_ASSERTIONS
`define CSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define CSD_ASSERT(label, prop, msg)
`endif

// clocked check, also during reset
`ifndef NO_ASSERTIONS
`define CSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CSD_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

@@ design/csdte_pkg.sv @@
package csdte_pkg;

    localparam int MEM_SIZE = 65536;
    localparam int MEM_AW = $clog2(MEM_SIZE);
    localparam int ADDR_W = 16;
    localparam int LEN_W = 18;
    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    typedef enum logic
    {
        OP_REGS = 1'b0,
        OP_MEM  = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        REC_HEADER = 2'd0,
        REC_CHANGE = 2'd1,
        REC_END    = 2'd2
    } rec_kind_t;

    typedef enum logic
    {
        BK_RUN,
        BK_END
    } back_state_t;

    // input transaction payload, last member in the lowest bits
    typedef struct packed {
        logic [7:0]        mem_byte;
        logic [ADDR_W-1:0] mem_address;
        logic [15:0]       counter_value;
        logic [7:0]        stack_value;
        logic [7:0]        status_value;
        logic [7:0]        index_y_value;
        logic [7:0]        index_x_value;
        logic [7:0]        acc_value;
        logic [31:0]       frame_number;
    } in_item_t;

    // output transaction payload, last member in the lowest bits
    typedef struct packed {
        logic [LEN_W-1:0]  frame_length;
        logic [7:0]        change_value;
        logic [ADDR_W-1:0] change_address;
        logic [15:0]       out_pc;
        logic [7:0]        out_stack;
        logic [7:0]        out_status;
        logic [7:0]        out_y;
        logic [7:0]        out_x;
        logic [7:0]        out_acc;
        logic [5:0]        changed_mask;
        logic [31:0]       frame_id;
    } rec_t;

    localparam int IN_DATA_W = $bits(in_item_t);
    localparam int OUT_DATA_W = $bits(rec_t);

    // classified item handed from front to back
    typedef struct packed {
        logic              is_mem;
        logic              last;
        logic              changed;
        logic [5:0]        mask;
        logic [31:0]       frame;
        logic [7:0]        acc;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [7:0]        status;
        logic [7:0]        stack;
        logic [15:0]       pc;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } cmd_t;

endpackage

@@ design/csdte_front.sv @@
`include "assert_macros.svh"

module csdte_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  csdte_pkg::in_item_t in_item,
    input  logic                in_op,
    output logic                push,
    output csdte_pkg::cmd_t     push_cmd,
    input  logic                q_full
);
    import csdte_pkg::*;

    logic [7:0]        snap_mem [MEM_SIZE];
    logic [7:0]        rdata_reg;
    logic [7:0]        fwd_reg;
    logic              hit_reg;
    logic              hit_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    cmd_t              s1_reg;
    cmd_t              s1_next;
    logic              clearing_reg;
    logic [MEM_AW-1:0] clr_addr_reg;

    logic [7:0]        prev_acc_reg;
    logic [7:0]        prev_x_reg;
    logic [7:0]        prev_y_reg;
    logic [7:0]        prev_status_reg;
    logic [7:0]        prev_stack_reg;
    logic [15:0]       prev_pc_reg;

    logic              accept;
    logic              is_mem;
    logic              in_range;
    logic              load_s1;
    logic              leave;
    logic              wr_en;
    logic [7:0]        old_byte;
    logic [5:0]        mask;
    logic [MEM_AW-1:0] mem_idx;

    always_comb
    begin
        in_ready = !clearing_reg && (!s1_valid_reg || !q_full);
        accept   = in_valid && in_ready;
        is_mem   = (op_t'(in_op) == OP_MEM);
        in_range = ({1'b0, in_item.mem_address} < (ADDR_W + 1)'(MEM_SIZE));
        load_s1  = accept && (!is_mem || in_range);
        leave    = s1_valid_reg && !q_full;
        mem_idx  = in_item.mem_address[MEM_AW-1:0];
        old_byte = hit_reg ? fwd_reg : rdata_reg;

        mask[0] = in_item.acc_value != prev_acc_reg;
        mask[1] = in_item.index_x_value != prev_x_reg;
        mask[2] = in_item.index_y_value != prev_y_reg;
        mask[3] = in_item.status_value != prev_status_reg;
        mask[4] = in_item.stack_value != prev_stack_reg;
        mask[5] = in_item.counter_value != prev_pc_reg;

        s1_next         = '0;
        s1_next.is_mem  = is_mem;
        s1_next.addr    = in_item.mem_address;
        s1_next.data    = in_item.mem_byte;
        s1_next.last    = is_mem && (in_item.mem_address == ADDR_W'(MEM_SIZE - 1));
        if (!is_mem)
        begin
            s1_next.frame  = in_item.frame_number;
            s1_next.mask   = mask;
            s1_next.acc    = mask[0] ? in_item.acc_value : 8'd0;
            s1_next.x      = mask[1] ? in_item.index_x_value : 8'd0;
            s1_next.y      = mask[2] ? in_item.index_y_value : 8'd0;
            s1_next.status = mask[3] ? in_item.status_value : 8'd0;
            s1_next.stack  = mask[4] ? in_item.stack_value : 8'd0;
            s1_next.pc     = mask[5] ? in_item.counter_value : 16'd0;
            s1_next.addr   = '0;
            s1_next.data   = '0;
        end

        // byte still being written by the stage ahead
        hit_next = s1_valid_reg && s1_reg.is_mem && (s1_reg.addr == in_item.mem_address);

        s1_valid_next = load_s1 ? 1'b1 : (leave ? 1'b0 : s1_valid_reg);

        push             = leave;
        push_cmd         = s1_reg;
        push_cmd.changed = s1_reg.is_mem && (old_byte != s1_reg.data);
        wr_en            = leave && push_cmd.changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            prev_acc_reg    <= '0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            prev_status_reg <= '0;
            prev_stack_reg  <= '0;
            prev_pc_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == MEM_AW'(MEM_SIZE - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept && !is_mem)
            begin
                prev_acc_reg    <= in_item.acc_value;
                prev_x_reg      <= in_item.index_x_value;
                prev_y_reg      <= in_item.index_y_value;
                prev_status_reg <= in_item.status_value;
                prev_stack_reg  <= in_item.stack_value;
                prev_pc_reg     <= in_item.counter_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_reg  <= s1_next;
            hit_reg <= hit_next;
            fwd_reg <= s1_reg.data;
        end
    end

    // snapshot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            snap_mem[clr_addr_reg] <= 8'd0;
        end
        else if (wr_en)
        begin
            snap_mem[s1_reg.addr[MEM_AW-1:0]] <= s1_reg.data;
        end
        if (load_s1)
        begin
            rdata_reg <= snap_mem[mem_idx];
        end
    end

    `CSD_ASSERT(a_s1_holds, s1_valid_reg && q_full |=> s1_valid_reg && $stable(s1_reg), "stalled stage lost its item")

endmodule

@@ design/csdte_queue.sv @@
`include "assert_macros.svh"

module csdte_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csdte_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            not_empty,
    output csdte_pkg::cmd_t head
);
    import csdte_pkg::*;

    cmd_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    always_comb
    begin
        full      = (count_reg == QCW'(QDEPTH));
        not_empty = (count_reg != '0);
        head      = entry_reg[rd_ptr_reg];
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `CSD_ASSERT_ALWAYS(a_count_bound, !rst_n || count_reg <= QCW'(QDEPTH), "count beyond depth")
    `CSD_ASSERT(a_count_up, push && !pop |=> count_reg == $past(count_reg) + QCW'(1), "queue count did not grow")

endmodule

@@ design/csdte_back.sv @@
`include "assert_macros.svh"

module csdte_back
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  csdte_pkg::cmd_t                      q_cmd,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [csdte_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [1:0]                           m_tuser
);
    import csdte_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;
    logic             out_valid_reg;
    rec_kind_t        out_kind_reg;
    rec_t             out_rec_reg;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;

    logic             load_ok;
    logic             load;
    rec_kind_t        kind;
    rec_t             rec;
    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] len_plus3;

    always_comb
    begin
        load_ok   = !out_valid_reg || m_tready;
        hdr_len   = LEN_W'(3) + LEN_W'(q_cmd.mask[0]) + LEN_W'(q_cmd.mask[1])
                  + LEN_W'(q_cmd.mask[2]) + LEN_W'(q_cmd.mask[3])
                  + LEN_W'(q_cmd.mask[4]) + LEN_W'({q_cmd.mask[5], 1'b0});
        len_plus3 = (length_reg > (LEN_MAX - LEN_W'(3))) ? LEN_MAX
                                                          : length_reg + LEN_W'(3);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (q_valid && load_ok && q_cmd.is_mem && q_cmd.changed && q_cmd.last)
                begin
                    state_next = BK_END;
                end
            end
            BK_END:
            begin
                if (load_ok)
                begin
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        load        = 1'b0;
        kind        = REC_HEADER;
        rec         = '0;
        length_next = length_reg;
        unique case (state_reg)
            BK_RUN:
            begin
                if (q_valid && load_ok)
                begin
                    pop = 1'b1;
                    if (!q_cmd.is_mem)
                    begin
                        load             = 1'b1;
                        kind             = REC_HEADER;
                        rec.frame_id     = q_cmd.frame;
                        rec.changed_mask = q_cmd.mask;
                        rec.out_acc      = q_cmd.acc;
                        rec.out_x        = q_cmd.x;
                        rec.out_y        = q_cmd.y;
                        rec.out_status   = q_cmd.status;
                        rec.out_stack    = q_cmd.stack;
                        rec.out_pc       = q_cmd.pc;
                        length_next      = hdr_len;
                    end
                    else if (q_cmd.changed)
                    begin
                        load               = 1'b1;
                        kind               = REC_CHANGE;
                        rec.change_address = q_cmd.addr;
                        rec.change_value   = q_cmd.data;
                        length_next        = len_plus3;
                    end
                    else if (q_cmd.last)
                    begin
                        load             = 1'b1;
                        kind             = REC_END;
                        rec.frame_length = length_reg;
                    end
                end
            end
            BK_END:
            begin
                if (load_ok)
                begin
                    load             = 1'b1;
                    kind             = REC_END;
                    rec.frame_length = length_reg;
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_RUN;
            out_valid_reg <= 1'b0;
            length_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            length_reg <= length_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= kind;
            out_rec_reg  <= rec;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rec_reg;
    assign m_tuser  = out_kind_reg;

    `CSD_ASSERT(a_end_follows_change, state_reg == BK_END |-> out_valid_reg && out_kind_reg == REC_CHANGE, "end record pending without change record")

endmodule

@@ design/cpu_state_delta_trace_encoder.sv @@
// channel   dir  tdata                                   tuser
// s_*       in   frame, a, x, y, p, s, pc, addr, byte    operation
// m_*       out  frame_id, mask, a, x, y, p, s, pc,      record_kind
//                change addr, change value, length
//
// one input transaction per cycle via the snapshot memory read/compare/write pipeline, while the queue has room
// a record passes the front stage register, the queue and the output register before it reaches m_tdata
// the last address with a changed byte gives two records, a change record and then an end record
// after reset all 65536 snapshot bytes are cleared with s_tready low
// a 4-entry queue lets input and output stall independently

module cpu_state_delta_trace_encoder
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // frame_number, acc, x, y, status, stack, counter, mem_address, mem_byte
    input  logic [csdte_pkg::IN_DATA_W-1:0]     s_tdata,
    // operation
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // frame_id, changed_mask, out_acc, out_x, out_y, out_status, out_stack,
    // out_pc, change_address, change_value, frame_length
    output logic [csdte_pkg::OUT_DATA_W-1:0]    m_tdata,
    // record_kind
    output logic [1:0]                          m_tuser
);
    import csdte_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic pop;
    logic q_valid;
    cmd_t q_head;

    csdte_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (s_tdata),
        .in_op    (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    csdte_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    csdte_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
